>>> design/aes_pkg.sv
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumStages = NumRounds + 1;

  typedef enum logic [0:0] {
    OpEncrypt = 1'b0,
    OpDecrypt = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    RegKeyHigh = 1'b0,
    RegKeyLow  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        opcode;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  typedef logic [127:0] blk_t;

  localparam logic [7:0] SboxFwd [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] SboxInv [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] Rcon [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] get_byte(blk_t s, int unsigned i);
    get_byte = s[127 - 8 * i -: 8];
  endfunction

  function automatic blk_t sub_bytes(blk_t s, logic inv);
    blk_t r;
    for (int i = 0; i < 16; i++) begin
      r[127 - 8 * i -: 8] = inv ? SboxInv[get_byte(s, i)] : SboxFwd[get_byte(s, i)];
    end
    sub_bytes = r;
  endfunction

  function automatic blk_t shift_rows(blk_t s, logic inv);
    blk_t r;
    for (int rr = 0; rr < 4; rr++) begin
      for (int c = 0; c < 4; c++) begin
        r[127 - 8 * (rr + 4 * c) -: 8] = inv ? get_byte(s, rr + 4 * ((c + 3 * rr) % 4))
                                              : get_byte(s, rr + 4 * ((c + rr) % 4));
      end
    end
    shift_rows = r;
  endfunction

  function automatic blk_t mix_fwd(blk_t s);
    blk_t r;
    logic [7:0] a [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = get_byte(s, 4 * c + k);
      for (int rr = 0; rr < 4; rr++) begin
        r[127 - 8 * (4 * c + rr) -: 8] = xtime(a[rr]) ^ xtime(a[(rr + 1) % 4])
            ^ a[(rr + 1) % 4] ^ a[(rr + 2) % 4] ^ a[(rr + 3) % 4];
      end
    end
    mix_fwd = r;
  endfunction

  function automatic blk_t mix_inv(blk_t s);
    blk_t r;
    logic [7:0] a [4];
    logic [7:0] x2, x4, x8;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = get_byte(s, 4 * c + k);
      for (int rr = 0; rr < 4; rr++) begin
        r[127 - 8 * (4 * c + rr) -: 8] = 8'h00;
        for (int k = 0; k < 4; k++) begin
          x2 = xtime(a[(rr + k) % 4]);
          x4 = xtime(x2);
          x8 = xtime(x4);
          unique case (k)
            0: r[127 - 8 * (4 * c + rr) -: 8] ^= x8 ^ x4 ^ x2;
            1: r[127 - 8 * (4 * c + rr) -: 8] ^= x8 ^ x2 ^ a[(rr + k) % 4];
            2: r[127 - 8 * (4 * c + rr) -: 8] ^= x8 ^ x4 ^ a[(rr + k) % 4];
            default: r[127 - 8 * (4 * c + rr) -: 8] ^= x8 ^ a[(rr + k) % 4];
          endcase
        end
      end
    end
    mix_inv = r;
  endfunction

  function automatic blk_t next_round_key(blk_t k, logic [7:0] rc);
    blk_t r;
    logic [31:0] t;
    t = {SboxFwd[k[23:16]] ^ rc, SboxFwd[k[15:8]], SboxFwd[k[7:0]], SboxFwd[k[31:24]]};
    r[127:96] = k[127:96] ^ t;
    r[95:64]  = k[95:64] ^ r[127:96];
    r[63:32]  = k[63:32] ^ r[95:64];
    r[31:0]   = k[31:0] ^ r[63:32];
    next_round_key = r;
  endfunction

endpackage

>>> design/aes_key_sched.sv
module aes_key_sched (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [63:0]       cfg_data_i,
  output aes_pkg::blk_t     rk_o [aes_pkg::NumStages]
);

  logic [63:0] key_high_q, key_low_q;
  aes_pkg::blk_t rk_q [aes_pkg::NumStages];
  aes_pkg::blk_t rk_d [aes_pkg::NumStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (aes_pkg::reg_idx_e'(cfg_idx_i))
        aes_pkg::RegKeyHigh: key_high_q <= cfg_data_i;
        aes_pkg::RegKeyLow:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // one expansion step per cycle; each round key register is computed from the one before it
  always_comb begin
    rk_d[0] = {key_high_q, key_low_q};
    for (int r = 1; r < aes_pkg::NumStages; r++) begin
      rk_d[r] = aes_pkg::next_round_key(rk_q[r - 1], aes_pkg::Rcon[r - 1]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < aes_pkg::NumStages; r++) rk_q[r] <= rk_d[r];
  end

  assign rk_o = rk_q;

endmodule

>>> design/aes_round.sv
module aes_round (
  input  aes_pkg::blk_t s_i,
  input  logic          inv_i,
  input  logic          last_i,
  input  aes_pkg::blk_t rk_i,
  output aes_pkg::blk_t s_o
);

  aes_pkg::blk_t t;

  always_comb begin
    if (!inv_i) begin
      t = aes_pkg::shift_rows(aes_pkg::sub_bytes(s_i, 1'b0), 1'b0);
      if (!last_i) t = aes_pkg::mix_fwd(t);
      s_o = t ^ rk_i;
    end else begin
      t = aes_pkg::sub_bytes(aes_pkg::shift_rows(s_i, 1'b1), 1'b1) ^ rk_i;
      s_o = last_i ? t : aes_pkg::mix_inv(t);
    end
  end

endmodule

>>> design/aes128_block_cipher_unit.sv
// Throughput: one item per cycle while the pipe is not stalled; an input key-add
// stage, ten round stages and an output register, each round stage one round, all
// stages halting on out_stall_i while the output register holds an item.
// Reset: asynchronous active low; clears valid bits and zeroes the key.
// Round keys are recomputed register by register in the key schedule after a key write.
module aes128_block_cipher_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  aes_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output aes_pkg::out_item_t out_data_o
);

  localparam int unsigned N = aes_pkg::NumStages;

  aes_pkg::blk_t rk [N];
  aes_pkg::blk_t s_q [N+1];
  logic          inv_q [N-1];
  logic [N:0]    vld_q;
  aes_pkg::blk_t s_d [N+1];
  logic          adv;

  aes_key_sched u_keys (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .rk_o(rk)
  );

  // stall the whole pipe only if the output holds an item
  assign adv = !(out_stall_i && vld_q[N]);
  assign in_stall_o = !adv;

  always_comb begin
    s_d[0] = {in_data_i.block_high, in_data_i.block_low}
             ^ (in_data_i.opcode ? rk[N-1] : rk[0]);
  end

  for (genvar g = 1; g <= N - 1; g++) begin : g_round
    aes_round u_round (
      .s_i(s_q[g-1]),
      .inv_i(inv_q[g-1]),
      .last_i(g == N - 1),
      .rk_i(inv_q[g-1] ? rk[N-1-g] : rk[g]),
      .s_o(s_d[g])
    );
  end

  assign s_d[N] = s_q[N-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[N-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q[0]   <= s_d[0];
      inv_q[0] <= in_data_i.opcode;
      for (int i = 1; i <= N; i++) begin
        s_q[i] <= s_d[i];
      end
      for (int i = 1; i < N - 1; i++) begin
        inv_q[i] <= inv_q[i-1];
      end
    end
  end

  assign out_valid_o = vld_q[N];
  assign out_data_o  = '{result_high: s_q[N][127:64], result_low: s_q[N][63:0]};

endmodule

>>> design/aes_checker.sv
module aes_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input aes_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind aes128_block_cipher_unit aes_checker u_aes_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
